/* hdl/ptm_pkg.sv */
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, codes and the control program of the page table mapper.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int IDX_W     = 9;   // index bits per table level (512 entries)
  localparam int FRAME_W   = 40;
  localparam int FRAME_X_W = 41;  // frame plus carry room
  localparam int VPAGE_W   = 36;
  localparam int COUNT_W   = 16;
  localparam int ENTRY_W   = 64;
  localparam int PAB_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'd1;

  localparam logic [PAB_W-1:0] PAB_RESET = 6'd40;
  localparam logic [PAB_W-1:0] PAB_MIN   = 6'd13;
  localparam logic [PAB_W-1:0] PAB_MAX   = 6'd52;
  localparam logic [PAB_W-1:0] PAGE_SHIFT = 6'd12;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MAPPED    = 2'd1;
  localparam status_t ST_NO_TABLES = 2'd2;
  localparam status_t ST_FRAME_BIG = 2'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_CLEAR     = 4'd1;
  localparam op_t OP_ACCEPT    = 4'd2;
  localparam op_t OP_PAGE_INIT = 4'd3;
  localparam op_t OP_READ      = 4'd4;
  localparam op_t OP_LATCH     = 4'd5;
  localparam op_t OP_WALK      = 4'd6;
  localparam op_t OP_SET_NEED  = 4'd7;
  localparam op_t OP_CALC      = 4'd8;
  localparam op_t OP_LINK      = 4'd9;
  localparam op_t OP_LEAF      = 4'd10;
  localparam op_t OP_ST_MAPPED = 4'd11;
  localparam op_t OP_ST_TABLES = 4'd12;
  localparam op_t OP_ST_FRAME  = 4'd13;
  localparam op_t OP_RESULT    = 4'd14;

  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER       = 4'd0;
  localparam cond_t C_ALWAYS      = 4'd1;
  localparam cond_t C_CLR_BUSY    = 4'd2;
  localparam cond_t C_NO_INPUT    = 4'd3;
  localparam cond_t C_ALL_DONE    = 4'd4;
  localparam cond_t C_BROKEN      = 4'd5;
  localparam cond_t C_ABSENT      = 4'd6;
  localparam cond_t C_LVL_LT3     = 4'd7;
  localparam cond_t C_NEED_NZ     = 4'd8;
  localparam cond_t C_PRESENT     = 4'd9;
  localparam cond_t C_FRAME_BIG   = 4'd10;
  localparam cond_t C_ALLOC_BIG   = 4'd11;
  localparam cond_t C_NO_ROOM     = 4'd12;
  localparam cond_t C_LVL_EQ3     = 4'd13;
  localparam cond_t C_OUT_BLOCKED = 4'd14;

  typedef logic [4:0] step_t;
  localparam step_t S_CLEAR       = 5'd0;
  localparam step_t S_IDLE        = 5'd1;
  localparam step_t S_PAGE        = 5'd2;
  localparam step_t S_WALK_RD     = 5'd3;
  localparam step_t S_WALK_LAT    = 5'd4;
  localparam step_t S_WALK_EVAL   = 5'd5;
  localparam step_t S_WALK_MISS   = 5'd6;
  localparam step_t S_WALK_NEXT   = 5'd7;
  localparam step_t S_LEAF_RD     = 5'd8;
  localparam step_t S_LEAF_LAT    = 5'd9;
  localparam step_t S_LEAF_EVAL   = 5'd10;
  localparam step_t S_CHK_FRAME   = 5'd11;
  localparam step_t S_CHK_ALLOC   = 5'd12;
  localparam step_t S_CHK_ROOM    = 5'd13;
  localparam step_t S_LINK_TEST   = 5'd14;
  localparam step_t S_LINK_WR     = 5'd15;
  localparam step_t S_LEAF_WR     = 5'd16;
  localparam step_t S_FAIL_MAPPED = 5'd17;
  localparam step_t S_FAIL_TABLES = 5'd18;
  localparam step_t S_FAIL_FRAME  = 5'd19;
  localparam step_t S_RESULT      = 5'd20;
  localparam step_t S_RETURN      = 5'd21;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Control store: one word per step. Jump to target when cond holds,
  // else advance to the next step.
  function automatic ucode_t ptm_ucode(input step_t s);
    ucode_t w;
    w = '{OP_NOP, C_ALWAYS, S_IDLE};
    case (s)
      S_CLEAR:       w = '{OP_CLEAR,     C_CLR_BUSY,    S_CLEAR};
      S_IDLE:        w = '{OP_ACCEPT,    C_NO_INPUT,    S_IDLE};
      S_PAGE:        w = '{OP_PAGE_INIT, C_ALL_DONE,    S_RESULT};
      S_WALK_RD:     w = '{OP_READ,      C_NEVER,       S_IDLE};
      S_WALK_LAT:    w = '{OP_LATCH,     C_NEVER,       S_IDLE};
      S_WALK_EVAL:   w = '{OP_WALK,      C_BROKEN,      S_FAIL_TABLES};
      S_WALK_MISS:   w = '{OP_SET_NEED,  C_ABSENT,      S_CHK_FRAME};
      S_WALK_NEXT:   w = '{OP_NOP,       C_LVL_LT3,     S_WALK_RD};
      S_LEAF_RD:     w = '{OP_READ,      C_NEED_NZ,     S_CHK_FRAME};
      S_LEAF_LAT:    w = '{OP_LATCH,     C_NEVER,       S_IDLE};
      S_LEAF_EVAL:   w = '{OP_NOP,       C_PRESENT,     S_FAIL_MAPPED};
      S_CHK_FRAME:   w = '{OP_CALC,      C_FRAME_BIG,   S_FAIL_FRAME};
      S_CHK_ALLOC:   w = '{OP_NOP,       C_ALLOC_BIG,   S_FAIL_FRAME};
      S_CHK_ROOM:    w = '{OP_NOP,       C_NO_ROOM,     S_FAIL_TABLES};
      S_LINK_TEST:   w = '{OP_NOP,       C_LVL_EQ3,     S_LEAF_WR};
      S_LINK_WR:     w = '{OP_LINK,      C_ALWAYS,      S_LINK_TEST};
      S_LEAF_WR:     w = '{OP_LEAF,      C_ALWAYS,      S_PAGE};
      S_FAIL_MAPPED: w = '{OP_ST_MAPPED, C_ALWAYS,      S_RESULT};
      S_FAIL_TABLES: w = '{OP_ST_TABLES, C_ALWAYS,      S_RESULT};
      S_FAIL_FRAME:  w = '{OP_ST_FRAME,  C_ALWAYS,      S_RESULT};
      S_RESULT:      w = '{OP_RESULT,    C_OUT_BLOCKED, S_RESULT};
      S_RETURN:      w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
      default:       w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/ptm_ram.sv */
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 32768,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/page_table_mapper_unit.sv */
// ----------------------------------------------------------------------------
// page_table_mapper_unit
// Maps runs of pages into a four-level page table held in a local store.
// ----------------------------------------------------------------------------
// Each transfer on the input asks for page_count consecutive pages to be
// mapped: page i gets frame start_frame+i at virtual page start_vpage+i. For
// each page the block walks the four-level table (table 0 is the root),
// allocates missing interior tables from a bump counter, and writes the leaf.
// It stops at the first page that is already mapped, whose walk meets a link
// outside the tables, whose frame (or a new table's frame) lies above the
// configured physical width, or for which too few tables remain; a failing
// page writes nothing. One result transfer follows each input transfer with
// the status, the pages mapped and the number of table pages in use. After
// reset a clearing pass zeroes the store before the first input is taken.
// The table store has a single read in flight at a time, with its registered
// read data latched and checked over the following steps of the control
// program. A finished result waits in the output register while the next
// item is accepted. The user must write configuration only while idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module page_table_mapper_unit
  import ptm_pkg::*;
#(
  parameter int NUM_TABLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAME_W-1:0]   start_frame,
  input  logic [VPAGE_W-1:0]   start_vpage,
  input  logic [COUNT_W-1:0]   page_count,
  input  logic [1:0]           map_flags,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   pages_done,
  output logic [6:0]           tables_used
);

  localparam int TW    = $clog2(NUM_TABLES);      // table number bits
  localparam int NW    = $clog2(NUM_TABLES + 1);  // bump counter, holds NUM_TABLES
  localparam int DEPTH = NUM_TABLES * (1 << IDX_W);
  localparam int AW    = TW + IDX_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  // configuration registers
  logic [PAB_W-1:0]     phys_bits;
  logic [FRAME_W-1:0]   table_base;
  logic [PAB_W-1:0]     phys_clamped;
  logic [FRAME_X_W-1:0] lim;          // highest legal frame number

  // sequencer
  step_t  step;
  step_t  step_next;
  ucode_t uw;
  logic   cond_hit;

  // datapath
  logic [AW-1:0]        clr_cnt;
  logic [FRAME_X_W-1:0] frame;
  logic [VPAGE_W-1:0]   vpage;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   done;
  logic [1:0]           flags;
  logic [1:0]           lvl;
  logic [TW-1:0]        cur;
  logic [1:0]           need;
  logic [NW-1:0]        nft;
  logic                 ent_present;
  logic [FRAME_X_W-1:0] tdiff;
  logic [FRAME_X_W-1:0] alloc_top;
  status_t              st;

  logic                 accept;
  logic                 broken;
  logic [IDX_W-1:0]     ix;
  logic [FRAME_X_W-1:0] link_frame;
  logic [FRAME_W-1:0]   ent_frame;

  // store ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      phys_bits  <= PAB_RESET;
      table_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHYS_BITS:  phys_bits  <= cfg_data[PAB_W-1:0];
        CFG_TABLE_BASE: table_base <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the width to its legal range and hold the frame limit in a register.
  always_comb begin
    if (phys_bits < PAB_MIN) begin
      phys_clamped = PAB_MIN;
    end else if (phys_bits > PAB_MAX) begin
      phys_clamped = PAB_MAX;
    end else begin
      phys_clamped = phys_bits;
    end
  end

  always_ff @(posedge clk) begin
    lim <= (FRAME_X_W'(1) << (phys_clamped - PAGE_SHIFT)) - FRAME_X_W'(1);
  end

  // ------------------------------------------------------------- sequencer
  assign uw       = ptm_ucode(step);
  assign in_stall = (step != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Index for the current level: virtual page bits 35..27, 26..18, 17..9, 8..0.
  always_comb begin
    case (lvl)
      2'd0:    ix = vpage[35:27];
      2'd1:    ix = vpage[26:18];
      2'd2:    ix = vpage[17:9];
      default: ix = vpage[8:0];
    endcase
  end

  assign broken     = ent_present &&
                      (tdiff[FRAME_X_W-1] || (tdiff[FRAME_W-1:0] >= FRAME_W'(NUM_TABLES)));
  assign link_frame = {1'b0, table_base} + FRAME_X_W'(nft);

  always_comb begin
    case (uw.cond)
      C_NEVER:       cond_hit = 1'b0;
      C_ALWAYS:      cond_hit = 1'b1;
      C_CLR_BUSY:    cond_hit = (clr_cnt != CLR_LAST);
      C_NO_INPUT:    cond_hit = !in_valid;
      C_ALL_DONE:    cond_hit = (done == count);
      C_BROKEN:      cond_hit = broken;
      C_ABSENT:      cond_hit = !ent_present;
      C_LVL_LT3:     cond_hit = (lvl != 2'd3);
      C_NEED_NZ:     cond_hit = (need != 2'd0);
      C_PRESENT:     cond_hit = ent_present;
      C_FRAME_BIG:   cond_hit = (frame > lim);
      C_ALLOC_BIG:   cond_hit = (need != 2'd0) && (alloc_top > lim);
      C_NO_ROOM:     cond_hit = (({1'b0, nft} + (NW + 1)'(need)) > (NW + 1)'(NUM_TABLES));
      C_LVL_EQ3:     cond_hit = (lvl == 2'd3);
      C_OUT_BLOCKED: cond_hit = out_valid && out_stall;
      default:       cond_hit = 1'b0;
    endcase
  end

  assign step_next = cond_hit ? uw.target : step_t'(step + step_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  // --------------------------------------------------------- table store
  assign ent_frame = ram_rdata[51:12] & lim[FRAME_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {cur, ix};
    ram_wdata = '0;
    ram_re    = 1'b0;
    case (uw.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      OP_READ: begin
        ram_re = 1'b1;
      end
      OP_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = {11'd0, link_frame, 10'd0, 2'b11};
      end
      OP_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = {11'd0, frame, 9'd0, flags[1], flags[0], 1'b1};
      end
      default: ;
    endcase
  end

  ptm_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr ({cur, ix}),
    .rd_data (ram_rdata)
  );

  // -------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      nft       <= NW'(1);
      out_valid <= 1'b0;
    end else begin
      // advance the clearing sweep; it parks on the last entry
      if (uw.op == OP_CLEAR && clr_cnt != CLR_LAST) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (uw.op == OP_LINK) begin
        nft <= nft + NW'(1);
      end
      if (uw.op == OP_RESULT && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (accept) begin
          frame <= {1'b0, start_frame};
          vpage <= start_vpage;
          count <= page_count;
          flags <= map_flags;
          done  <= '0;
          st    <= ST_OK;
        end
      end
      OP_PAGE_INIT: begin
        lvl  <= 2'd0;
        cur  <= '0;
        need <= 2'd0;
      end
      OP_LATCH: begin
        ent_present <= ram_rdata[0];
        tdiff       <= {1'b0, ent_frame} - {1'b0, table_base};
      end
      OP_WALK: begin
        if (ent_present && !broken) begin
          cur <= tdiff[TW-1:0];
          lvl <= lvl + 2'd1;
        end
      end
      OP_SET_NEED: begin
        if (!ent_present) begin
          need <= 2'd3 - lvl;
        end
      end
      OP_CALC: begin
        alloc_top <= link_frame + FRAME_X_W'(need) - FRAME_X_W'(1);
      end
      OP_LINK: begin
        cur <= nft[TW-1:0];
        lvl <= lvl + 2'd1;
      end
      OP_LEAF: begin
        done  <= done + COUNT_W'(1);
        frame <= frame + FRAME_X_W'(1);
        vpage <= vpage + VPAGE_W'(1);
      end
      OP_ST_MAPPED: st <= ST_MAPPED;
      OP_ST_TABLES: st <= ST_NO_TABLES;
      OP_ST_FRAME:  st <= ST_FRAME_BIG;
      OP_RESULT: begin
        if (!(out_valid && out_stall)) begin
          status      <= st;
          pages_done  <= done;
          tables_used <= 7'(nft);
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ assertions
  // A result appears only from the result step of the program.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step == S_RESULT))
    else $error("result raised outside the result step");

  // No input is taken before the clearing sweep has reached the last entry.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> (clr_cnt == CLR_LAST))
    else $error("input accepted before the store was cleared");

  // Link and leaf writes go only to the root or to tables already allocated.
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && (uw.op == OP_LINK || uw.op == OP_LEAF)) |-> (NW'(cur) < nft))
    else $error("write to a table that was never allocated");

endmodule
